[hw/rtl/hsl_pkg.sv]
// Shared widths, constants and types for the HSL to RGB converter.
// No dependencies; RTL files use scoped names, the sim files import the package.
package hsl_pkg;

    localparam int HUE_W = 9;     // hue in whole degrees
    localparam int PCT_W = 7;     // saturation and luminance in whole percent
    localparam int CH_W  = 8;     // one color channel
    localparam int LVL_W = 14;    // intermediate levels in units of 1/10000
    localparam int NUM_W = 20;    // ramp numerator, level times 600000
    localparam int RMP_W = 6;     // ramp slope factor, 0..60

    localparam int LANES      = 3;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    localparam int HUE_TURN   = 360;
    localparam int HUE_THIRD  = 120;
    localparam int HUE_2THIRD = 240;
    localparam int HUE_SIXTH  = 60;
    localparam int HUE_HALF   = 180;
    localparam int PCT_MAX    = 100;
    localparam int PCT_HALF   = 50;
    localparam int RAMP_DEN   = 600000;
    localparam int RAMP_ODD   = 9375;    // odd factor of RAMP_DEN
    localparam int RAMP_SHIFT = 6;       // RAMP_DEN is RAMP_ODD shifted left by this

    typedef logic [LANES-1:0][HUE_W-1:0] hue_vec_t;
    typedef logic [LANES-1:0][NUM_W-1:0] num_vec_t;
    typedef logic [LANES-1:0][CH_W-1:0]  rgb_t;

    // Upper and lower levels plus the three hue arguments of one request.
    typedef struct packed {
        logic [LVL_W-1:0] hi;
        logic [LVL_W-1:0] lo;
        hue_vec_t         hue;
    } lvl_t;

endpackage

[hw/rtl/hsl_if.sv]
// Valid/ready channel interfaces for the HSL to RGB converter.
// Depends on hsl_pkg for the field widths.
interface hsl_in_if;
    logic                        valid;
    logic                        ready;
    logic [hsl_pkg::HUE_W-1:0]   hue_degrees;
    logic [hsl_pkg::PCT_W-1:0]   saturation_pct;
    logic [hsl_pkg::PCT_W-1:0]   luminance_pct;

    modport source (output valid, hue_degrees, saturation_pct, luminance_pct, input ready);
    modport sink   (input valid, hue_degrees, saturation_pct, luminance_pct, output ready);
endinterface

interface hsl_out_if;
    logic                       valid;
    logic                       ready;
    logic [hsl_pkg::CH_W-1:0]   red;
    logic [hsl_pkg::CH_W-1:0]   green;
    logic [hsl_pkg::CH_W-1:0]   blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

[hw/rtl/hsl_lvl.sv]
// Front end: input clamping stage and the stage that forms the two levels
// and the three hue arguments. Depends on hsl_pkg.
module hsl_lvl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [hsl_pkg::HUE_W-1:0]  hue_degrees,
    input  logic [hsl_pkg::PCT_W-1:0]  saturation_pct,
    input  logic [hsl_pkg::PCT_W-1:0]  luminance_pct,
    output logic                       lvl_valid,
    output hsl_pkg::lvl_t              lvl
);

    logic                      vld0_reg;
    logic                      vld1_reg;
    logic [hsl_pkg::HUE_W-1:0] hue_reg, hue_next;
    logic [hsl_pkg::PCT_W-1:0] sat_reg, sat_next;
    logic [hsl_pkg::PCT_W-1:0] lum_reg, lum_next;
    hsl_pkg::lvl_t             lvl_reg, lvl_next;

    logic [15:0]               hi_wide;
    logic [15:0]               lo_wide;
    logic [hsl_pkg::HUE_W:0]   hue_red;

    // Hue 360 and above wraps once; saturation and luminance clip at 100.
    always_comb
    begin
        hue_next = (hue_degrees >= hsl_pkg::HUE_W'(hsl_pkg::HUE_TURN))
                   ? hue_degrees - hsl_pkg::HUE_W'(hsl_pkg::HUE_TURN) : hue_degrees;
        sat_next = (saturation_pct > hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX))
                   ? hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX) : saturation_pct;
        lum_next = (luminance_pct > hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX))
                   ? hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX) : luminance_pct;
    end

    // With zero saturation both levels equal 100 times luminance, which
    // makes every ramp flat and yields the grey value directly.
    always_comb
    begin
        if (lum_reg < hsl_pkg::PCT_W'(hsl_pkg::PCT_HALF))
        begin
            hi_wide = 16'(lum_reg) * (16'(sat_reg) + 16'(hsl_pkg::PCT_MAX));
        end
        else
        begin
            hi_wide = 16'(hsl_pkg::PCT_MAX) * (16'(lum_reg) + 16'(sat_reg))
                      - 16'(sat_reg) * 16'(lum_reg);
        end
        lo_wide = 16'(2 * hsl_pkg::PCT_MAX) * 16'(lum_reg) - hi_wide;

        hue_red = 10'(hue_reg) + 10'(hsl_pkg::HUE_THIRD);
        if (hue_red > 10'(hsl_pkg::HUE_TURN))
        begin
            hue_red = hue_red - 10'(hsl_pkg::HUE_TURN);
        end

        lvl_next.hi = hi_wide[hsl_pkg::LVL_W-1:0];
        lvl_next.lo = lo_wide[hsl_pkg::LVL_W-1:0];
        lvl_next.hue[hsl_pkg::LANE_RED]   = hue_red[hsl_pkg::HUE_W-1:0];
        lvl_next.hue[hsl_pkg::LANE_GREEN] = hue_reg;
        lvl_next.hue[hsl_pkg::LANE_BLUE]  =
            (hue_reg < hsl_pkg::HUE_W'(hsl_pkg::HUE_THIRD))
            ? hue_reg + hsl_pkg::HUE_W'(hsl_pkg::HUE_2THIRD)
            : hue_reg - hsl_pkg::HUE_W'(hsl_pkg::HUE_THIRD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            lum_reg <= lum_next;
            lvl_reg <= lvl_next;
        end
    end

    assign lvl_valid = vld1_reg;
    assign lvl       = lvl_reg;

endmodule

[hw/rtl/hsl_ramp.sv]
// Hue ramp stage: turns the two levels and three hue arguments into three
// channel numerators over 600000. Depends on hsl_pkg.
module hsl_ramp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              lvl_valid,
    input  hsl_pkg::lvl_t     lvl,
    output logic              num_valid,
    output hsl_pkg::num_vec_t num
);

    logic                      vld_reg;
    hsl_pkg::num_vec_t         num_reg, num_next;
    logic [hsl_pkg::LVL_W-1:0] diff;
    logic [hsl_pkg::RMP_W-1:0] slope [hsl_pkg::LANES];

    // Every ramp segment is lo*60 + (hi - lo)*f, where f rises 0..60 on the
    // first sixth, holds at 60 to one half, falls back by two thirds, then is 0.
    always_comb
    begin
        diff = lvl.hi - lvl.lo;
        for (int l = 0; l < hsl_pkg::LANES; l++)
        begin
            if (lvl.hue[l] < hsl_pkg::HUE_W'(hsl_pkg::HUE_SIXTH))
            begin
                slope[l] = lvl.hue[l][hsl_pkg::RMP_W-1:0];
            end
            else if (lvl.hue[l] < hsl_pkg::HUE_W'(hsl_pkg::HUE_HALF))
            begin
                slope[l] = hsl_pkg::RMP_W'(hsl_pkg::HUE_SIXTH);
            end
            else if (lvl.hue[l] < hsl_pkg::HUE_W'(hsl_pkg::HUE_2THIRD))
            begin
                slope[l] = hsl_pkg::RMP_W'(hsl_pkg::HUE_W'(hsl_pkg::HUE_2THIRD) - lvl.hue[l]);
            end
            else
            begin
                slope[l] = '0;
            end
            num_next[l] = hsl_pkg::NUM_W'(lvl.lo) * hsl_pkg::NUM_W'(hsl_pkg::HUE_SIXTH)
                        + hsl_pkg::NUM_W'(diff) * hsl_pkg::NUM_W'(slope[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= lvl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
        end
    end

    assign num_valid = vld_reg;
    assign num       = num_reg;

endmodule

[hw/rtl/hsl_div.sv]
// Pipelined division by 600000 for all three channels as a reciprocal
// multiplication with round-up, then scaling by 255. Depends on hsl_pkg.
module hsl_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              num_valid,
    input  hsl_pkg::num_vec_t num,
    output logic              rgb_valid,
    output hsl_pkg::rgb_t     rgb
);

    // 600000 is 9375 shifted left by 6, so num * 2**FRAC_BITS / 600000 is the
    // scaled numerator num * 2**(FRAC_BITS-6) over 9375. Adding 9374 first
    // turns the truncating quotient into the rounded-up one.
    localparam int STG = 4;                      // bias, products, sum, scale
    localparam int QW  = FRAC_BITS + 1;          // quotient reaches 2**FRAC_BITS
    localparam int NW  = hsl_pkg::NUM_W + FRAC_BITS - hsl_pkg::RAMP_SHIFT;
    localparam int SH  = NW + $clog2(hsl_pkg::RAMP_ODD);
    localparam int MW  = NW + 1;                 // reciprocal width
    localparam int HW  = 24;                     // multiplier split point
    localparam int LLW = 2 * HW;
    localparam int PW  = NW + MW;                // full product
    localparam int HHW = PW - LLW;
    localparam int CW  = QW + hsl_pkg::CH_W;     // quotient times 255

    // With the shift one divisor width above the numerator width, the
    // rounded-up reciprocal gives the exact quotient for every numerator.
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(hsl_pkg::RAMP_ODD - 1)) / 64'(hsl_pkg::RAMP_ODD);
    localparam logic [MW-1:0]    RCP    = MW'(RECIP);
    localparam logic [HW-1:0]    RCP_LO = RCP[HW-1:0];
    localparam logic [MW-HW-1:0] RCP_HI = RCP[MW-1:HW];

    logic [STG-1:0]                vld_reg;
    logic [NW-1:0]                 scl_reg  [hsl_pkg::LANES];
    logic [NW-1:0]                 scl_next [hsl_pkg::LANES];
    logic [LLW-1:0]                pll_reg  [hsl_pkg::LANES];
    logic [LLW-1:0]                pll_next [hsl_pkg::LANES];
    logic [MW-1:0]                 plh_reg  [hsl_pkg::LANES];
    logic [MW-1:0]                 plh_next [hsl_pkg::LANES];
    logic [NW-1:0]                 phl_reg  [hsl_pkg::LANES];
    logic [NW-1:0]                 phl_next [hsl_pkg::LANES];
    logic [HHW-1:0]                phh_reg  [hsl_pkg::LANES];
    logic [HHW-1:0]                phh_next [hsl_pkg::LANES];
    logic [QW-1:0]                 fx_reg   [hsl_pkg::LANES];
    logic [QW-1:0]                 fx_next  [hsl_pkg::LANES];
    hsl_pkg::rgb_t                 rgb_reg, rgb_next;

    logic [PW-1:0]                 prod;
    logic [CW-1:0]                 scaled;

    always_comb
    begin
        prod   = '0;
        scaled = '0;
        for (int l = 0; l < hsl_pkg::LANES; l++)
        begin
            scl_next[l] = (NW'(num[l]) << (FRAC_BITS - hsl_pkg::RAMP_SHIFT))
                        + NW'(hsl_pkg::RAMP_ODD - 1);
            // Four partial products of the split numerator and reciprocal.
            pll_next[l] = LLW'(scl_reg[l][HW-1:0]) * LLW'(RCP_LO);
            plh_next[l] = MW'(scl_reg[l][HW-1:0]) * MW'(RCP_HI);
            phl_next[l] = NW'(scl_reg[l][NW-1:HW]) * NW'(RCP_LO);
            phh_next[l] = HHW'(scl_reg[l][NW-1:HW]) * HHW'(RCP_HI);
            prod = (PW'(phh_reg[l]) << LLW)
                 + ((PW'(plh_reg[l]) + PW'(phl_reg[l])) << HW)
                 + PW'(pll_reg[l]);
            fx_next[l] = prod[SH +: QW];
            scaled = {fx_reg[l], {hsl_pkg::CH_W{1'b0}}} - CW'(fx_reg[l]);
            rgb_next[l] = scaled[FRAC_BITS +: hsl_pkg::CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STG-2:0], num_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scl_reg <= scl_next;
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            phh_reg <= phh_next;
            fx_reg  <= fx_next;
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = vld_reg[STG-1];
    assign rgb       = rgb_reg;

endmodule

[hw/rtl/hsl_to_rgb_converter.sv]
// HSL to RGB converter: takes one request per clock cycle (hue in degrees,
// saturation and luminance in percent) and returns 8-bit red, green and blue.
// The pipeline is a clamping stage, the stage that forms the two levels,
// the hue ramp stage and four divider stages that round each level up into
// FRAC_BITS fraction bits by reciprocal multiplication and scale it by 255.
// Throughput is one request per cycle with no gaps; the whole pipeline stalls
// only when a result is held in the output skid register, and one request is
// still taken in the first cycle that the output is back-pressured.
// Depends on hsl_pkg, hsl_if, hsl_lvl, hsl_ramp and hsl_div.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    hsl_in_if.sink       pix_in,
    hsl_out_if.source    pix_out
);

    logic              pipe_en;
    logic              lvl_valid;
    hsl_pkg::lvl_t     lvl;
    logic              num_valid;
    hsl_pkg::num_vec_t num;
    logic              res_valid;
    hsl_pkg::rgb_t     res;
    logic              skid_valid_reg;
    hsl_pkg::rgb_t     skid_reg;
    hsl_pkg::rgb_t     out_rgb;

    assign pipe_en      = !skid_valid_reg;
    assign pix_in.ready = pipe_en;

    hsl_lvl u_lvl (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (pipe_en),
        .in_valid       (pix_in.valid),
        .hue_degrees    (pix_in.hue_degrees),
        .saturation_pct (pix_in.saturation_pct),
        .luminance_pct  (pix_in.luminance_pct),
        .lvl_valid      (lvl_valid),
        .lvl            (lvl)
    );

    hsl_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .lvl_valid (lvl_valid),
        .lvl       (lvl),
        .num_valid (num_valid),
        .num       (num)
    );

    hsl_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .num_valid (num_valid),
        .num       (num),
        .rgb_valid (res_valid),
        .rgb       (res)
    );

    // The skid register holds the older result; the pipeline's last stage
    // stays frozen behind it until it has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pix_out.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid && !pix_out.ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && res_valid && !pix_out.ready)
        begin
            skid_reg <= res;
        end
    end

    assign out_rgb       = skid_valid_reg ? skid_reg : res;
    assign pix_out.valid = skid_valid_reg || res_valid;
    assign pix_out.red   = out_rgb[hsl_pkg::LANE_RED];
    assign pix_out.green = out_rgb[hsl_pkg::LANE_GREEN];
    assign pix_out.blue  = out_rgb[hsl_pkg::LANE_BLUE];

endmodule

[sim/hsl_to_rgb_converter_check.sv]
// Checker for the HSL to RGB converter: watches both channels, predicts the
// color of every accepted request and compares it with the returned result.
// Depends on hsl_pkg for widths and constants and on hsl_if for the channels.
module hsl_to_rgb_converter_check #(
    parameter int FRAC_BITS = 24
) (
    input  logic  clk,
    input  logic  rst_n,
    hsl_in_if     pix_in,
    hsl_out_if    pix_out,
    output int    mismatches,
    output int    colors_waiting,
    output int    colors_checked
);
    import hsl_pkg::*;

    rgb_t rgb_expected[$];
    rgb_t rgb_want;

    // Level num/RAMP_DEN, rounded up into Q1.FRAC_BITS, then scaled by 255
    // and truncated.
    function automatic logic [CH_W-1:0] level_to_byte(input longint unsigned num);
        longint unsigned fx;
        fx = ((num << FRAC_BITS) + RAMP_DEN - 1) / RAMP_DEN;
        return CH_W'((fx * 255) >> FRAC_BITS);
    endfunction

    // Hue ramp numerator in units of 1/RAMP_DEN for a hue in whole degrees.
    function automatic longint unsigned ramp_num(input longint unsigned lo,
                                                 input longint unsigned hi,
                                                 input longint unsigned h);
        longint unsigned d;
        d = hi - lo;
        if (h < HUE_SIXTH)
            return lo * HUE_SIXTH + d * h;
        if (h < HUE_HALF)
            return hi * HUE_SIXTH;
        if (h < HUE_2THIRD)
            return lo * HUE_SIXTH + d * (HUE_2THIRD - h);
        return lo * HUE_SIXTH;
    endfunction

    function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] hue_in,
                                         input logic [PCT_W-1:0] sat_in,
                                         input logic [PCT_W-1:0] lum_in);
        longint unsigned hue, sat, lum, hi, lo, h_red, h_blue;
        rgb_t rgb;
        hue = hue_in;
        if (hue >= HUE_TURN)
            hue -= HUE_TURN;
        sat = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
        lum = (lum_in > PCT_MAX) ? PCT_MAX : lum_in;

        if (sat == 0)
        begin
            rgb[LANE_RED]   = level_to_byte(lum * (RAMP_DEN / PCT_MAX));
            rgb[LANE_GREEN] = rgb[LANE_RED];
            rgb[LANE_BLUE]  = rgb[LANE_RED];
            return rgb;
        end

        if (lum < PCT_HALF)
            hi = lum * (PCT_MAX + sat);
        else
            hi = PCT_MAX * (lum + sat) - sat * lum;
        lo = 2 * PCT_MAX * lum - hi;

        // A red argument of exactly one turn is kept and falls to the lower level.
        h_red = hue + HUE_THIRD;
        if (h_red > HUE_TURN)
            h_red -= HUE_TURN;
        h_blue = (hue < HUE_THIRD) ? hue + HUE_2THIRD : hue - HUE_THIRD;

        rgb[LANE_RED]   = level_to_byte(ramp_num(lo, hi, h_red));
        rgb[LANE_GREEN] = level_to_byte(ramp_num(lo, hi, hue));
        rgb[LANE_BLUE]  = level_to_byte(ramp_num(lo, hi, h_blue));
        return rgb;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_expected.delete();
            mismatches     = 0;
            colors_waiting = 0;
            colors_checked = 0;
        end
        else
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result r=%0d g=%0d b=%0d",
                                 pix_out.red, pix_out.green, pix_out.blue);
                end
                else
                begin
                    rgb_want = rgb_expected.pop_front();
                    colors_checked++;
                    if (rgb_want[LANE_RED] !== pix_out.red ||
                        rgb_want[LANE_GREEN] !== pix_out.green ||
                        rgb_want[LANE_BLUE] !== pix_out.blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     colors_checked, rgb_want[LANE_RED], rgb_want[LANE_GREEN],
                                     rgb_want[LANE_BLUE], pix_out.red, pix_out.green,
                                     pix_out.blue);
                    end
                end
            end
            if (pix_in.valid && pix_in.ready)
                rgb_expected.push_back(predict_rgb(pix_in.hue_degrees,
                                                   pix_in.saturation_pct,
                                                   pix_in.luminance_pct));
            colors_waiting = rgb_expected.size();
        end
    end

endmodule

[sim/hsl_to_rgb_converter_tb.sv]
// Top of the HSL to RGB converter testbench: clock, reset, request stimulus
// and output back-pressure; the checker beside the block does the comparing.
// Depends on hsl_pkg, hsl_if, hsl_to_rgb_converter and hsl_to_rgb_converter_check.
module hsl_to_rgb_converter_tb;
    import hsl_pkg::*;

    localparam int FRAC_BITS    = 24;
    localparam int LATENCY      = 7;
    localparam int RANDOM_COLORS = 1500;
    localparam int LONG_HOLD    = 300;

    logic clk;
    logic rst_n;
    bit   gaps_on;
    bit   hold_req;
    bit   hold_done;
    int   colors_sent;
    int   directed_sent;
    int   mismatches;
    int   colors_waiting;
    int   colors_checked;

    hsl_in_if  pix_in ();
    hsl_out_if pix_out ();

    hsl_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    hsl_to_rgb_converter_check #(.FRAC_BITS(FRAC_BITS)) u_color_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_in         (pix_in),
        .pix_out        (pix_out),
        .mismatches     (mismatches),
        .colors_waiting (colors_waiting),
        .colors_checked (colors_checked)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("hsl_to_rgb_converter test failed");
        $finish;
    end

    // Output back-pressure: short random bursts, plus one long hold on request.
    initial
    begin
        pix_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                pix_out.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                pix_out.ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_color(input int hue, input int sat, input int lum);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        pix_in.valid          <= 1'b1;
        pix_in.hue_degrees    <= HUE_W'(hue);
        pix_in.saturation_pct <= PCT_W'(sat);
        pix_in.luminance_pct  <= PCT_W'(lum);
        do
            @(posedge clk);
        while (!pix_in.ready);
        colors_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_color();
        int hue;
        int sat;
        int lum;
        int pick;
        pick = $urandom_range(0, 99);
        hue  = (pick < 10) ? $urandom_range(0, 511) : $urandom_range(0, HUE_TURN);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            sat = 0;
        else if (pick < 16)
            sat = $urandom_range(0, 127);
        else
            sat = $urandom_range(0, PCT_MAX);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            lum = $urandom_range(0, 127);
        else if (pick < 14)
            lum = $urandom_range(0, 1) ? PCT_MAX : 0;
        else
            lum = $urandom_range(0, PCT_MAX);
        send_color(hue, sat, lum);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        gaps_on               = 1'b1;
        hold_req              = 1'b0;
        colors_sent           = 0;
        pix_in.valid          = 1'b0;
        pix_in.hue_degrees    = '0;
        pix_in.saturation_pct = '0;
        pix_in.luminance_pct  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Ramp breakpoints and both sides of each, at full saturation.
        send_color(0, PCT_MAX, PCT_HALF);
        send_color(59, PCT_MAX, PCT_HALF);
        send_color(HUE_SIXTH, PCT_MAX, PCT_HALF);
        send_color(HUE_THIRD, PCT_MAX, PCT_HALF);
        send_color(179, PCT_MAX, PCT_HALF);
        send_color(HUE_HALF, PCT_MAX, PCT_HALF);
        send_color(239, PCT_MAX, PCT_HALF);
        // Red argument lands exactly on a full turn here.
        send_color(HUE_2THIRD, PCT_MAX, PCT_HALF);
        send_color(300, PCT_MAX, PCT_HALF);
        send_color(359, PCT_MAX, PCT_HALF);
        // Hue of a full turn and beyond wraps once.
        send_color(HUE_TURN, PCT_MAX, PCT_HALF);
        send_color(361, 60, 40);
        send_color(511, 100, 70);
        // Grey colors from zero saturation.
        send_color(200, 0, 0);
        send_color(17, 0, PCT_HALF);
        send_color(511, 0, PCT_MAX);
        send_color(90, 0, 127);
        // Out-of-range saturation and luminance clamp to full scale.
        send_color(45, 127, 127);
        send_color(300, 127, 30);
        // Luminance extremes and the lower/upper formula boundary.
        send_color(150, PCT_MAX, 0);
        send_color(150, PCT_MAX, PCT_MAX);
        send_color(10, 1, 1);
        send_color(210, 73, PCT_HALF - 1);
        send_color(210, 73, PCT_HALF);
        send_color(330, 1, 99);
        directed_sent = colors_sent;

        for (int i = 0; i < RANDOM_COLORS; i++)
        begin
            // Long output hold while requests keep coming, so the pipeline backs up.
            if (i == 400)
                hold_req = 1'b1;
            // Let the pipeline drain completely before continuing.
            if (i == 900)
            begin
                pix_in.valid <= 1'b0;
                @(negedge clk);
                while (colors_waiting != 0)
                    @(negedge clk);
            end
            if (i == RANDOM_COLORS - 250)
                gaps_on = 1'b0;
            send_random_color();
        end
        pix_in.valid <= 1'b0;

        while (colors_waiting != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("Sent %0d color requests (%0d directed: ramp breakpoints, hue wrap, grey,",
                 colors_sent, directed_sent);
        $display("clamped fields) under random and long back-pressure; %0d results checked.",
                 colors_checked);
        if (mismatches == 0 && colors_waiting == 0)
            $display("hsl_to_rgb_converter test passed");
        else
            $display("hsl_to_rgb_converter test failed");
        $finish;
    end

endmodule

[hsl_to_rgb_converter.f]
hw/rtl/hsl_pkg.sv
hw/rtl/hsl_if.sv
hw/rtl/hsl_lvl.sv
hw/rtl/hsl_ramp.sv
hw/rtl/hsl_div.sv
hw/rtl/hsl_to_rgb_converter.sv
sim/hsl_to_rgb_converter_check.sv
sim/hsl_to_rgb_converter_tb.sv
